/* rtl/csfr_pkg.sv */
// ----------------------------------------------------------------------------
// csfr_pkg
// Shared types and constants of the checksummed frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package csfr_pkg;

    // Frame geometry: header, FRAME_LEN-2 payload bytes, checksum.
    localparam int FRAME_LEN    = 8;
    localparam int STORE_DEPTH  = FRAME_LEN - 1;
    localparam int IDX_W        = $clog2(STORE_DEPTH);
    localparam int POS_W        = $clog2(FRAME_LEN);
    localparam int BYTE_W       = 8;
    localparam int BYTE_INDEX_W = 3;
    localparam int M_TDATA_W    = 16;
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;

    // Request kinds carried on s_tuser.
    localparam logic REQ_BYTE    = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // Register indexes (word addresses on the configuration port).
    localparam logic [1:0] REG_NORMAL_HEADER   = 2'd0;
    localparam logic [1:0] REG_DOWNLOAD_HEADER = 2'd1;
    localparam logic [1:0] REG_BRIDGE_HEADER   = 2'd2;

    localparam logic [BYTE_W-1:0] NORMAL_HEADER_RST   = 8'd170;
    localparam logic [BYTE_W-1:0] DOWNLOAD_HEADER_RST = 8'd171;
    localparam logic [BYTE_W-1:0] BRIDGE_HEADER_RST   = 8'd172;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_RECV,
        ST_FETCH,
        ST_SEND
    } state_t;

endpackage : csfr_pkg

`default_nettype wire

/* rtl/checksummed_frame_receiver.sv */
// ----------------------------------------------------------------------------
// checksummed_frame_receiver
// Finds fixed checksummed frames in a byte stream and emits the stored
// header and payload bytes of every frame whose checksum matches.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake         Contents
//  s_        in         tvalid / tready   tdata: data_byte; tuser: req_type
//  m_        out        tvalid / tready   tdata: frame_byte, byte_index; tlast
//  APB       in/out     psel / penable    three 8-bit header registers
//
// While receiving, one word is accepted in every cycle. A byte that completes
// a frame with a good checksum starts the emission of the seven stored bytes,
// each of which is first read from the frame store and then offered on the
// output, and the input is held off until the last of them has been taken.
// Stalls on the output simply extend the emission. Reset is synchronous and
// active low; the frame store is not cleared, since only bytes written in the
// current frame are ever read back.
//
`default_nettype none

module checksummed_frame_receiver (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [csfr_pkg::BYTE_W-1:0]         s_tdata,   // [7:0] data_byte
    input  wire logic                                s_tuser,   // [0] req_type
    // Result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [csfr_pkg::M_TDATA_W-1:0]           m_tdata,   // [7:0] frame_byte,
                                                                // [10:8] byte_index
    output logic                                     m_tlast,   // last_byte
    // Configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [csfr_pkg::PADDR_W-1:0]        paddr,
    input  wire logic [csfr_pkg::PDATA_W-1:0]        pwdata,
    output logic [csfr_pkg::PDATA_W-1:0]             prdata,
    output logic                                     pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [csfr_pkg::BYTE_W-1:0] normal_hdr_reg;
    logic [csfr_pkg::BYTE_W-1:0] download_hdr_reg;
    logic [csfr_pkg::BYTE_W-1:0] bridge_hdr_reg;
    logic                        cfg_wr;
    logic [1:0]                  cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_sel = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            normal_hdr_reg   <= csfr_pkg::NORMAL_HEADER_RST;
            download_hdr_reg <= csfr_pkg::DOWNLOAD_HEADER_RST;
            bridge_hdr_reg   <= csfr_pkg::BRIDGE_HEADER_RST;
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                csfr_pkg::REG_NORMAL_HEADER:   normal_hdr_reg   <= pwdata[7:0];
                csfr_pkg::REG_DOWNLOAD_HEADER: download_hdr_reg <= pwdata[7:0];
                csfr_pkg::REG_BRIDGE_HEADER:   bridge_hdr_reg   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            csfr_pkg::REG_NORMAL_HEADER:   prdata = {24'd0, normal_hdr_reg};
            csfr_pkg::REG_DOWNLOAD_HEADER: prdata = {24'd0, download_hdr_reg};
            csfr_pkg::REG_BRIDGE_HEADER:   prdata = {24'd0, bridge_hdr_reg};
            default:                       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    csfr_pkg::state_t             state_reg, state_next;
    logic [csfr_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [csfr_pkg::BYTE_W-1:0]  sum_reg, sum_next;
    logic                         kind_reg, kind_next;   // frame may restart
    logic                         pend_reg, pend_next;
    logic [csfr_pkg::IDX_W-1:0]   rd_idx_reg, rd_idx_next;

    // Frame store: one synchronous memory with a registered read port.
    logic [csfr_pkg::BYTE_W-1:0]  frame_mem [csfr_pkg::STORE_DEPTH];
    logic [csfr_pkg::BYTE_W-1:0]  mem_q;
    logic                         wr_en;
    logic [csfr_pkg::IDX_W-1:0]   wr_addr;
    logic                         rd_en;

    logic                         in_fire;
    logic                         emit_start;
    logic                         rd_last;
    logic [csfr_pkg::BYTE_W-1:0]  rx_byte;

    assign in_fire = s_tvalid & s_tready;
    assign rx_byte = s_tdata;
    assign rd_last = (rd_idx_reg == csfr_pkg::IDX_W'(csfr_pkg::STORE_DEPTH - 1));

    // Reads only happen during emission and writes only while receiving, so
    // the two ports of the store never touch the same entry in one cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            frame_mem[wr_addr] <= rx_byte;
        end
        if (rd_en) begin
            mem_q <= frame_mem[rd_idx_reg];
        end
    end

    // Byte parsing: decides the next parser state and the store write.
    always_comb begin
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        kind_next  = kind_reg;
        pend_next  = pend_reg;
        wr_en      = 1'b0;
        wr_addr    = '0;
        emit_start = 1'b0;

        if (in_fire) begin
            if (s_tuser == csfr_pkg::REQ_RELEASE) begin
                pend_next = 1'b0;
            end else if (!pend_reg) begin
                if (pos_reg == '0) begin
                    // Waiting for a header; the normal kind wins on overlap.
                    if (rx_byte == normal_hdr_reg) begin
                        sum_next  = rx_byte;
                        kind_next = 1'b1;
                        pos_next  = csfr_pkg::POS_W'(1);
                        wr_en     = 1'b1;
                    end else if (rx_byte == download_hdr_reg ||
                                 rx_byte == bridge_hdr_reg) begin
                        sum_next  = rx_byte;
                        kind_next = 1'b0;
                        pos_next  = csfr_pkg::POS_W'(1);
                        wr_en     = 1'b1;
                    end
                end else if (pos_reg <= csfr_pkg::POS_W'(csfr_pkg::FRAME_LEN - 2)) begin
                    if (kind_reg && rx_byte == normal_hdr_reg) begin
                        // A normal header inside a normal frame restarts it.
                        sum_next  = rx_byte;
                        kind_next = 1'b1;
                        pos_next  = csfr_pkg::POS_W'(1);
                        wr_en     = 1'b1;
                    end else begin
                        sum_next  = sum_reg + rx_byte;
                        pos_next  = pos_reg + csfr_pkg::POS_W'(1);
                        wr_en     = 1'b1;
                        wr_addr   = pos_reg[csfr_pkg::IDX_W-1:0];
                    end
                end else begin
                    // Checksum position; anything else beyond is treated alike
                    // by returning to idle.
                    sum_next  = '0;
                    pos_next  = '0;
                    kind_next = 1'b0;
                    if (pos_reg == csfr_pkg::POS_W'(csfr_pkg::FRAME_LEN - 1) &&
                        sum_reg == rx_byte) begin
                        pend_next  = 1'b1;
                        emit_start = 1'b1;
                    end
                end
            end
        end
    end

    // Next state of the sequencer.
    always_comb begin
        state_next  = state_reg;
        rd_idx_next = rd_idx_reg;
        unique case (state_reg)
            csfr_pkg::ST_RECV: begin
                if (emit_start) begin
                    state_next  = csfr_pkg::ST_FETCH;
                    rd_idx_next = '0;
                end
            end
            csfr_pkg::ST_FETCH: begin
                state_next = csfr_pkg::ST_SEND;
            end
            csfr_pkg::ST_SEND: begin
                if (m_tready) begin
                    if (rd_last) begin
                        state_next = csfr_pkg::ST_RECV;
                    end else begin
                        state_next  = csfr_pkg::ST_FETCH;
                        rd_idx_next = rd_idx_reg + csfr_pkg::IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = csfr_pkg::ST_RECV;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        s_tready = 1'b0;
        rd_en    = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            csfr_pkg::ST_RECV:  s_tready = 1'b1;
            csfr_pkg::ST_FETCH: rd_en    = 1'b1;
            csfr_pkg::ST_SEND:  m_tvalid = 1'b1;
            default: ;
        endcase
    end

    // The read data register holds steady while a word waits on the output.
    assign m_tdata = {{(csfr_pkg::M_TDATA_W - csfr_pkg::BYTE_W - csfr_pkg::BYTE_INDEX_W){1'b0}},
                      csfr_pkg::BYTE_INDEX_W'(rd_idx_reg), mem_q};
    assign m_tlast = rd_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= csfr_pkg::ST_RECV;
            pos_reg    <= '0;
            sum_reg    <= '0;
            kind_reg   <= 1'b0;
            pend_reg   <= 1'b0;
            rd_idx_reg <= '0;
        end else begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
            kind_reg   <= kind_next;
            pend_reg   <= pend_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

endmodule : checksummed_frame_receiver

`default_nettype wire

/* rtl/csfr_checker.sv */
// ----------------------------------------------------------------------------
// csfr_checker
// Port-level assertions for the checksummed frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module csfr_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [csfr_pkg::M_TDATA_W-1:0]    m_tdata,
    input wire logic                              m_tlast
);

    // A stalled output word holds its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("output word changed while stalled");

    // Input is never taken while a frame is being emitted.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready during emission");

    // Within a frame the next word follows with the next byte index.
    a_index_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> ##1
        (m_tvalid && m_tdata[10:8] == 3'($past(m_tdata[10:8], 2) + 3'd1)))
        else $error("byte index did not advance");

    // After the last word the block listens again.
    a_resume: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("receiver did not resume after frame");

endmodule : csfr_checker

bind checksummed_frame_receiver csfr_checker u_csfr_checker (.*);

`default_nettype wire

/* sim/checksummed_frame_receiver_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksummed_frame_receiver_test
// Self-checking testbench of the checksummed frame receiver. A byte stream is
// offered on the input channel, and a frame tracker in the testbench keeps
// its own parser state and header settings. Every word of an accepted frame
// is queued when its checksum byte is taken. A checker compares each output
// word with the oldest queued one. Both channels idle at random, the output
// is held off once for a long stretch, and the three header registers are
// moved through several settings between phases.
// ----------------------------------------------------------------------------

module checksummed_frame_receiver_test;

    // One emitted frame word as the output channel carries it.
    typedef struct packed {
        logic [csfr_pkg::BYTE_W-1:0]       frame_byte;
        logic [csfr_pkg::BYTE_INDEX_W-1:0] byte_index;
        logic                              last_byte;
    } frame_word_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [csfr_pkg::BYTE_W-1:0]    s_tdata  = '0;
    logic                           s_tuser  = csfr_pkg::REQ_BYTE;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [csfr_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tlast;
    logic                           psel     = 1'b0;
    logic                           penable  = 1'b0;
    logic                           pwrite   = 1'b0;
    logic [csfr_pkg::PADDR_W-1:0]   paddr    = '0;
    logic [csfr_pkg::PDATA_W-1:0]   pwdata   = '0;
    logic [csfr_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;

    checksummed_frame_receiver u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] data_byte
        .s_tuser  (s_tuser),   // [0] req_type
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [7:0] frame_byte, [10:8] byte_index
        .m_tlast  (m_tlast),   // last_byte
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 2 ns clock period.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Frame words that the tracker says must still come out, oldest first.
    frame_word_t expected_frame_words[$];
    frame_word_t want_word;
    int          errors     = 0;
    int          words_used = 0;

    // Shadow copies of the header registers.
    logic [csfr_pkg::BYTE_W-1:0] hdr_normal   = csfr_pkg::NORMAL_HEADER_RST;
    logic [csfr_pkg::BYTE_W-1:0] hdr_download = csfr_pkg::DOWNLOAD_HEADER_RST;
    logic [csfr_pkg::BYTE_W-1:0] hdr_bridge   = csfr_pkg::BRIDGE_HEADER_RST;

    // Parser state of the frame tracker.
    int                          rx_pos         = 0;
    logic [csfr_pkg::BYTE_W-1:0] rx_sum         = '0;
    logic [csfr_pkg::BYTE_W-1:0] rx_store [csfr_pkg::STORE_DEPTH];
    logic                        rx_held        = 1'b0;
    logic                        rx_restartable = 1'b0;

    // Idling controls: steady flags switch idling off on either side, and
    // hold_left makes the receiver refuse words until it has counted down to zero.
    logic tx_steady = 1'b0;
    logic rx_steady = 1'b0;
    int   hold_left = 0;

    // ------------------------------------------------------------------
    // Frame tracker
    // ------------------------------------------------------------------

    // A header byte opens a frame; only the normal header may restart it.
    task automatic open_frame(input logic [csfr_pkg::BYTE_W-1:0] hdr,
                              input logic restartable);
        rx_sum         = hdr;
        rx_store[0]    = hdr;
        rx_restartable = restartable;
        rx_pos         = 1;
    endtask

    task automatic drop_frame();
        rx_sum         = '0;
        rx_pos         = 0;
        rx_restartable = 1'b0;
    endtask

    // Advances the tracker by one accepted input word and queues the frame
    // words that a matching checksum releases.
    task automatic track_rx_word(input logic req, input logic [csfr_pkg::BYTE_W-1:0] b);
        frame_word_t w;
        logic        sum_ok;
        words_used++;
        if (req == csfr_pkg::REQ_RELEASE) begin
            // A release only clears the pending flag and never emits.
            rx_held = 1'b0;
        end else if (!rx_held) begin
            if (rx_pos == 0) begin
                // The normal header wins where it equals another header.
                if (b == hdr_normal) begin
                    open_frame(b, 1'b1);
                end else if (b == hdr_download || b == hdr_bridge) begin
                    open_frame(b, 1'b0);
                end
            end else if (rx_pos <= csfr_pkg::FRAME_LEN - 2) begin
                if (rx_restartable && b == hdr_normal) begin
                    open_frame(b, 1'b1);
                end else begin
                    rx_sum           = rx_sum + b;
                    rx_store[rx_pos] = b;
                    rx_pos++;
                end
            end else if (rx_pos == csfr_pkg::FRAME_LEN - 1) begin
                // The checksum byte is only compared, even if it looks like
                // a header.
                sum_ok = (rx_sum == b);
                drop_frame();
                if (sum_ok) begin
                    rx_held = 1'b1;
                    for (int i = 0; i < csfr_pkg::STORE_DEPTH; i++) begin
                        w.frame_byte = rx_store[i];
                        w.byte_index = i[csfr_pkg::BYTE_INDEX_W-1:0];
                        w.last_byte  = (i == csfr_pkg::STORE_DEPTH - 1);
                        expected_frame_words.push_back(w);
                    end
                end
            end else begin
                drop_frame();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offers one word, waits for it to be taken, then idles now and then.
    // tvalid stays high when the next word follows at once.
    task automatic send_word(input logic req, input logic [csfr_pkg::BYTE_W-1:0] b);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        track_rx_word(req, b);
        if (!tx_steady && $urandom_range(0, 99) < 25) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    // Setup cycle, then access cycle until pready.
    task automatic write_header(input logic [1:0] idx,
                                input logic [csfr_pkg::BYTE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {8'h00, 8'($urandom_range(0, 255)), 8'h00, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            csfr_pkg::REG_NORMAL_HEADER:   hdr_normal   = value;
            csfr_pkg::REG_DOWNLOAD_HEADER: hdr_download = value;
            csfr_pkg::REG_BRIDGE_HEADER:   hdr_bridge   = value;
            default: ;
        endcase
    endtask

    // Stops offering words, waits for every queued frame word, then gives
    // the block time to finish any internal work.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_frame_words.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    // Sends one frame under the current header settings. With faults
    // allowed, the checksum may be wrong, the frame may stop short, a stray
    // byte may follow, and the release may be left out.
    task automatic send_random_frame(input logic allow_faults);
        logic [csfr_pkg::BYTE_W-1:0] hdr;
        logic [csfr_pkg::BYTE_W-1:0] b;
        logic [csfr_pkg::BYTE_W-1:0] sum;
        logic                        restartable;
        int                          cut;
        case ($urandom_range(0, 2))
            0:       hdr = hdr_normal;
            1:       hdr = hdr_download;
            default: hdr = hdr_bridge;
        endcase
        restartable = (hdr == hdr_normal);
        cut = (allow_faults && $urandom_range(0, 9) == 0) ?
              int'($urandom_range(1, 6)) : csfr_pkg::FRAME_LEN;
        sum = hdr;
        send_word(csfr_pkg::REQ_BYTE, hdr);
        for (int k = 1; k <= csfr_pkg::FRAME_LEN - 2 && k < cut; k++) begin
            b = 8'($urandom_range(0, 255));
            // Keep most frames whole; an occasional restart is left in.
            if (restartable && b == hdr_normal && $urandom_range(0, 9) != 0) begin
                b = b ^ 8'h01;
            end
            sum = sum + b;
            send_word(csfr_pkg::REQ_BYTE, b);
        end
        if (cut == csfr_pkg::FRAME_LEN) begin
            if (allow_faults && $urandom_range(0, 99) < 15) begin
                sum = sum + 8'($urandom_range(1, 255));
            end
            send_word(csfr_pkg::REQ_BYTE, sum);
            if (allow_faults && $urandom_range(0, 9) < 2) begin
                send_word(csfr_pkg::REQ_BYTE, 8'($urandom_range(0, 255)));
            end
            if (!allow_faults || $urandom_range(0, 9) != 0) begin
                send_word(csfr_pkg::REQ_RELEASE, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Mostly well-formed frames with random content, the rest loose bytes
    // and stray releases.
    task automatic run_random_traffic(input int n_words);
        int start;
        start = words_used;
        while (words_used - start < n_words) begin
            if ($urandom_range(0, 99) < 70) begin
                send_random_frame(1'b1);
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 4) == 0) begin
                        send_word(csfr_pkg::REQ_RELEASE, 8'($urandom_range(0, 255)));
                    end else begin
                        send_word(csfr_pkg::REQ_BYTE, 8'($urandom_range(0, 255)));
                    end
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------

    // A normal frame whose payload covers both byte extremes and whose
    // checksum equals the normal header; then a byte while pending, a
    // release, and a release with nothing pending.
    task automatic test_good_frame();
        logic [csfr_pkg::BYTE_W-1:0] payload [csfr_pkg::FRAME_LEN-2];
        logic [csfr_pkg::BYTE_W-1:0] sum;
        payload = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'h01};
        sum = hdr_normal;
        send_word(csfr_pkg::REQ_BYTE, hdr_normal);
        foreach (payload[k]) begin
            sum = sum + payload[k];
            send_word(csfr_pkg::REQ_BYTE, payload[k]);
        end
        send_word(csfr_pkg::REQ_BYTE, sum);
        send_word(csfr_pkg::REQ_BYTE, hdr_normal);
        send_word(csfr_pkg::REQ_RELEASE, 8'hFF);
        send_word(csfr_pkg::REQ_RELEASE, 8'h00);
        wait_drained();
    endtask

    // A loose byte while idle, then a normal frame that restarts on its own
    // header and finally ends with a wrong checksum.
    task automatic test_restart_and_mismatch();
        logic [csfr_pkg::BYTE_W-1:0] sum;
        send_word(csfr_pkg::REQ_BYTE, 8'h33);
        send_word(csfr_pkg::REQ_BYTE, hdr_normal);
        send_word(csfr_pkg::REQ_BYTE, 8'h11);
        send_word(csfr_pkg::REQ_BYTE, hdr_normal);
        sum = hdr_normal;
        for (int k = 1; k <= csfr_pkg::FRAME_LEN - 2; k++) begin
            sum = sum + k[csfr_pkg::BYTE_W-1:0];
            send_word(csfr_pkg::REQ_BYTE, k[csfr_pkg::BYTE_W-1:0]);
        end
        send_word(csfr_pkg::REQ_BYTE, sum + 8'd1);
        wait_drained();
    endtask

    // A download frame carries the normal header twice in its payload
    // without restarting, and is accepted.
    task automatic test_download_no_restart();
        logic [csfr_pkg::BYTE_W-1:0] payload [csfr_pkg::FRAME_LEN-2];
        logic [csfr_pkg::BYTE_W-1:0] sum;
        payload = '{hdr_normal, 8'h00, 8'hFF, hdr_normal, 8'h10, 8'h20};
        sum = hdr_download;
        send_word(csfr_pkg::REQ_BYTE, hdr_download);
        foreach (payload[k]) begin
            sum = sum + payload[k];
            send_word(csfr_pkg::REQ_BYTE, payload[k]);
        end
        send_word(csfr_pkg::REQ_BYTE, sum);
        send_word(csfr_pkg::REQ_RELEASE, 8'h5A);
        wait_drained();
    endtask

    // A stretch with no idling on either side, then random idling.
    task automatic test_random_traffic();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        run_random_traffic(60);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        run_random_traffic(110);
        wait_drained();
    endtask

    // The receiver refuses words for a long stretch while good frames keep
    // coming, so the block has to stop taking input.
    task automatic test_output_holdoff();
        hold_left = 400;
        repeat (3) send_random_frame(1'b0);
        wait_drained();
    endtask

    // Header settings at the extremes and with all three headers equal.
    task automatic test_header_settings();
        write_header(csfr_pkg::REG_NORMAL_HEADER, 8'h00);
        write_header(csfr_pkg::REG_DOWNLOAD_HEADER, 8'hFF);
        write_header(csfr_pkg::REG_BRIDGE_HEADER, 8'h5A);
        run_random_traffic(50);
        wait_drained();
        write_header(csfr_pkg::REG_NORMAL_HEADER, 8'h55);
        write_header(csfr_pkg::REG_DOWNLOAD_HEADER, 8'h55);
        write_header(csfr_pkg::REG_BRIDGE_HEADER, 8'h55);
        run_random_traffic(40);
        wait_drained();
        write_header(csfr_pkg::REG_NORMAL_HEADER, 8'hFF);
        write_header(csfr_pkg::REG_DOWNLOAD_HEADER, 8'h00);
        write_header(csfr_pkg::REG_BRIDGE_HEADER, 8'hFF);
        run_random_traffic(40);
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Receiver side and checker
    // ------------------------------------------------------------------

    // Output ready: random idling, steady stretches, and the long hold-off,
    // which is counted here so that it runs on while the sender is blocked.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left = hold_left - 1;
        end else if (rx_steady) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= 25);
        end
    end

    // Every word taken from the output is matched against the oldest
    // queued frame word, field by field.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_frame_words.size() == 0) begin
                $display("%0t: unexpected frame word, actual byte %02h index %0d last %0b",
                         $time, m_tdata[7:0], m_tdata[10:8], m_tlast);
                errors++;
            end else begin
                want_word = expected_frame_words.pop_front();
                if (m_tdata[7:0] !== want_word.frame_byte) begin
                    $display("%0t: frame_byte expected %02h actual %02h",
                             $time, want_word.frame_byte, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[10:8] !== want_word.byte_index) begin
                    $display("%0t: byte_index expected %0d actual %0d",
                             $time, want_word.byte_index, m_tdata[10:8]);
                    errors++;
                end
                if (m_tlast !== want_word.last_byte) begin
                    $display("%0t: last_byte expected %0b actual %0b",
                             $time, want_word.last_byte, m_tlast);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_good_frame();
        test_restart_and_mismatch();
        test_download_no_restart();
        test_random_traffic();
        test_output_holdoff();
        test_header_settings();
        wait_drained();
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog: a hung handshake or a frame word that never comes ends here.
    initial begin
        #1000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
